FILE: rtl/core/dtc_pkg.sv
// Shared types and constants for the debounced transport control core.
// No dependencies; imported by every module in rtl/core.
package dtc_pkg;

  // Width of the per-button stable counters.
  localparam int COUNT_WIDTH = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Register widths and reset values.
  localparam int DEB_WIDTH = 10;
  localparam int MSG_WIDTH = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam logic [DEB_WIDTH-1:0] DEB_RESET = 10'd50;
  localparam logic [MSG_WIDTH-1:0] MSG_RESET = 16'd500;
  localparam logic [MSG_WIDTH-1:0] MSG_MAX = {MSG_WIDTH{1'b1}};

  // Width used for the debounce compare, wide enough for both sides.
  localparam int CMP_WIDTH = (COUNT_WIDTH > DEB_WIDTH) ? COUNT_WIDTH : DEB_WIDTH;

  // Register indexes.
  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_MESSAGE  = 1'b1;

  // MIDI realtime bytes.
  localparam logic [7:0] BYTE_NONE  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'hFA;
  localparam logic [7:0] BYTE_CONT  = 8'hFB;
  localparam logic [7:0] BYTE_STOP  = 8'hFC;

  // Display codes.
  localparam logic [2:0] DISP_NONE = 3'd0;
  localparam logic [2:0] DISP_PLAY = 3'd1;
  localparam logic [2:0] DISP_HOLD = 3'd2;
  localparam logic [2:0] DISP_STOP = 3'd3;
  localparam logic [2:0] DISP_IDLE = 3'd4;
  localparam logic [2:0] DISP_BPM  = 3'd5;

  // Transport mode codes as reported on the port.
  localparam logic [1:0] TMODE_STOPPED = 2'd0;
  localparam logic [1:0] TMODE_PLAYING = 2'd1;
  localparam logic [1:0] TMODE_PAUSED  = 2'd2;

  // Transport state machine.
  typedef enum logic [2:0] {
    MODE_STOP  = 3'b001,
    MODE_PLAY  = 3'b010,
    MODE_PAUSE = 3'b100
  } mode_t;

  // One result item.
  typedef struct packed {
    logic [1:0] midi_count;
    logic [7:0] midi_first;
    logic [7:0] midi_second;
    logic [2:0] display_code;
    logic [1:0] transport_mode;
  } dtc_result_t;

endpackage

FILE: rtl/core/dtc_debounce.sv
// Per-button debounce: stable counter, previous level and press latch.
// Depends on dtc_pkg.
module dtc_debounce
  import dtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 level,
  input  logic [DEB_WIDTH-1:0] debounce_ticks,
  output logic                 act
);

  logic                   prev_level;
  logic                   prev_level_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   latched;
  logic                   latched_next;
  logic                   settled;

  always_comb begin
    if (level != prev_level) begin
      count_next = '0;
    end else if (count != COUNT_MAX) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
    settled = CMP_WIDTH'(count_next) > CMP_WIDTH'(debounce_ticks);
    act = settled && !level && !latched;
    latched_next = latched;
    if (settled) begin
      if (!level) begin
        latched_next = 1'b1;
      end else begin
        latched_next = 1'b0;
      end
    end
    prev_level_next = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b1;
      count      <= '0;
      latched    <= 1'b0;
    end else if (step) begin
      prev_level <= prev_level_next;
      count      <= count_next;
      latched    <= latched_next;
    end
  end

endmodule

FILE: rtl/core/dtc_transport.sv
// Transport mode machine, MIDI byte selection and message timeout.
// Depends on dtc_pkg.
module dtc_transport
  import dtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 play_act,
  input  logic                 stop_act,
  input  logic [MSG_WIDTH-1:0] message_ticks,
  output dtc_result_t          result
);

  mode_t                mode;
  mode_t                mode_next;
  logic                 msg_active;
  logic                 msg_active_next;
  logic [MSG_WIDTH-1:0] msg_elapsed;
  logic [MSG_WIDTH-1:0] msg_elapsed_next;
  logic [7:0]           play_byte;
  logic [2:0]           play_disp;
  mode_t                play_mode;
  logic [2:0]           disp;
  logic                 acted;

  always_comb begin
    // Play button steps the transport; an illegal code counts as stopped.
    case (mode)
      MODE_PLAY: begin
        play_mode = MODE_PAUSE;
        play_byte = BYTE_STOP;
        play_disp = DISP_HOLD;
      end
      MODE_PAUSE: begin
        play_mode = MODE_PLAY;
        play_byte = BYTE_CONT;
        play_disp = DISP_PLAY;
      end
      default: begin
        play_mode = MODE_PLAY;
        play_byte = BYTE_START;
        play_disp = DISP_PLAY;
      end
    endcase

    mode_next = mode;
    disp      = DISP_NONE;
    if (play_act) begin
      mode_next = play_mode;
      disp      = play_disp;
    end
    if (stop_act) begin
      mode_next = MODE_STOP;
      disp      = DISP_STOP;
    end
    acted = play_act || stop_act;

    result.midi_count  = {1'b0, play_act} + {1'b0, stop_act};
    result.midi_first  = play_act ? play_byte : (stop_act ? BYTE_STOP : BYTE_NONE);
    result.midi_second = (play_act && stop_act) ? BYTE_STOP : BYTE_NONE;

    // Message timer.
    msg_active_next  = msg_active;
    msg_elapsed_next = msg_elapsed;
    if (acted) begin
      msg_active_next  = 1'b1;
      msg_elapsed_next = '0;
    end else if (msg_active && msg_elapsed != MSG_MAX) begin
      msg_elapsed_next = msg_elapsed + 1'b1;
    end
    if (msg_active_next && msg_elapsed_next >= message_ticks) begin
      msg_active_next = 1'b0;
      disp = (mode_next == MODE_STOP) ? DISP_IDLE : DISP_BPM;
    end
    result.display_code = disp;

    case (mode_next)
      MODE_PLAY:  result.transport_mode = TMODE_PLAYING;
      MODE_PAUSE: result.transport_mode = TMODE_PAUSED;
      default:    result.transport_mode = TMODE_STOPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_STOP;
      msg_active  <= 1'b0;
      msg_elapsed <= '0;
    end else if (step) begin
      mode        <= mode_next;
      msg_active  <= msg_active_next;
      msg_elapsed <= msg_elapsed_next;
    end
  end

endmodule

FILE: rtl/core/debounced_transport_control_core.sv
// Top level of the debounced transport control core.
// Depends on dtc_pkg, dtc_debounce and dtc_transport.
//
// One input item is one millisecond tick carrying the active-low levels of the
// play and stop buttons. Every item yields exactly one result item with the
// MIDI realtime bytes sent (start FA, continue FB, stop FC), the display code
// and the transport mode after the tick. The block takes one item per clock
// while out_ready keeps results draining. An item is captured in the input
// register. All per-tick work (both debounce counters, the transport machine
// and the message timer) is a single short combinational pass into the result
// register, from which out_valid shows the result. A result waiting on
// out_ready lets one more item into the input register; with both registers
// full and out_ready low, in_ready drops. The user must write registers
// through cfg_write/cfg_index/cfg_data only while no item is in flight; the
// block does not enforce this. Index 0 is the debounce setting (10 bits,
// reset 50), index 1 the message time (16 bits, reset 500).
module debounced_transport_control_core
  import dtc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // Tick input
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      play_level,
  input  logic                      stop_level,
  // Result output
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                midi_count,
  output logic [7:0]                midi_first,
  output logic [7:0]                midi_second,
  output logic [2:0]                display_code,
  output logic [1:0]                transport_mode,
  // Register writes
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  logic [DEB_WIDTH-1:0] debounce_ticks;
  logic [MSG_WIDTH-1:0] message_ticks;

  // Input register.
  logic        in_full;
  logic        play_q;
  logic        stop_q;
  // Result register.
  logic        out_full;
  dtc_result_t out_q;

  logic        advance;
  logic        play_act;
  logic        stop_act;
  dtc_result_t result;

  // An item moves to the result register when the slot is free or draining.
  assign advance  = in_full && (!out_full || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEB_RESET;
      message_ticks  <= MSG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_ticks <= cfg_data[DEB_WIDTH-1:0];
        CFG_MESSAGE:  message_ticks  <= cfg_data[MSG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      play_q <= play_level;
      stop_q <= stop_level;
    end
  end

  // Play is evaluated before stop; both only read the captured tick.
  dtc_debounce u_play_deb (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .level          (play_q),
    .debounce_ticks (debounce_ticks),
    .act            (play_act)
  );

  dtc_debounce u_stop_deb (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .level          (stop_q),
    .debounce_ticks (debounce_ticks),
    .act            (stop_act)
  );

  dtc_transport u_transport (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .play_act      (play_act),
    .stop_act      (stop_act),
    .message_ticks (message_ticks),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid      = out_full;
  assign midi_count     = out_q.midi_count;
  assign midi_first     = out_q.midi_first;
  assign midi_second    = out_q.midi_second;
  assign display_code   = out_q.display_code;
  assign transport_mode = out_q.transport_mode;

`ifndef ASSERT_OFF
  // A captured tick that cannot advance must stay put.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(play_q) && $stable(stop_q))
    else $error("input register lost or changed a stalled item");

  // No bytes reported means both byte fields are empty.
  a_idle_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && midi_count == 2'd0 |-> midi_first == BYTE_NONE && midi_second == BYTE_NONE)
    else $error("byte fields set with no bytes sent");

  // Both buttons acting always end stopped with stop shown second.
  a_both_act: assert property (@(posedge clk) disable iff (rst)
    out_valid && midi_count == 2'd2 |->
      midi_second == BYTE_STOP && transport_mode == TMODE_STOPPED &&
      (display_code == DISP_STOP || display_code == DISP_IDLE))
    else $error("double action produced inconsistent result");

  // Reported mode and byte count stay within their legal codes.
  a_legal_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> transport_mode != 2'd3 && midi_count != 2'd3)
    else $error("illegal mode or byte count reported");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for debounced_transport_control_core: directed and random button ticks,
// each result checked against an in-bench model of debounce, transport and message timer.
// Depends on dtc_pkg and the core RTL only.
module tb_top;
  import dtc_pkg::*;

  localparam int STALL_PCT      = 30;    // percent of cycles each side idles
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES  = 4;     // margin for the input and result registers to drain
  localparam int MAX_REPORTS    = 10;
  localparam int BTN_PLAY       = 0;
  localparam int BTN_STOP       = 1;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      play_level = 1'b1;
  logic                      stop_level = 1'b1;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                midi_count;
  logic [7:0]                midi_first;
  logic [7:0]                midi_second;
  logic [2:0]                display_code;
  logic [1:0]                transport_mode;
  logic                      cfg_write = 1'b0;
  logic                      cfg_index = CFG_DEBOUNCE;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  debounced_transport_control_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .play_level     (play_level),
    .stop_level     (stop_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .midi_count     (midi_count),
    .midi_first     (midi_first),
    .midi_second    (midi_second),
    .display_code   (display_code),
    .transport_mode (transport_mode),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Transport model: our own copy of registers and per-button state.
  // ---------------------------------------------------------------------------
  logic [DEB_WIDTH-1:0]   deb_setting;
  logic [MSG_WIDTH-1:0]   msg_setting;
  logic [1:0]             model_mode;
  logic                   btn_prev  [2];
  logic [COUNT_WIDTH-1:0] btn_count [2];
  logic                   btn_latch [2];
  logic                   msg_on;
  logic [MSG_WIDTH-1:0]   msg_elapsed;

  dtc_result_t pending_results [$];   // results owed by the core, oldest first

  bit calm = 1'b0;                    // set for stretches with no idling on either side
  int ticks_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  // Count ticks of unchanged level; a press acts once past the debounce setting,
  // and only once until the level has been seen high again past the setting.
  function automatic logic button_acts(int b, logic level);
    logic acts;
    acts = 1'b0;
    if (level != btn_prev[b]) btn_count[b] = '0;
    else if (btn_count[b] != COUNT_MAX) btn_count[b] = btn_count[b] + 1'b1;
    if (btn_count[b] > deb_setting) begin
      if (!level && !btn_latch[b]) begin
        btn_latch[b] = 1'b1;
        acts = 1'b1;
      end else if (level) begin
        btn_latch[b] = 1'b0;
      end
    end
    btn_prev[b] = level;
    return acts;
  endfunction

  // One tick: play first, then stop, then the message timeout.
  function automatic dtc_result_t transport_tick(logic play, logic stop);
    dtc_result_t r;
    logic acted;
    r = '0;
    r.midi_first   = BYTE_NONE;
    r.midi_second  = BYTE_NONE;
    r.display_code = DISP_NONE;
    acted = 1'b0;
    if (button_acts(BTN_PLAY, play)) begin
      case (model_mode)
        TMODE_PLAYING: begin
          model_mode     = TMODE_PAUSED;
          r.midi_first   = BYTE_STOP;
          r.display_code = DISP_HOLD;
        end
        TMODE_PAUSED: begin
          model_mode     = TMODE_PLAYING;
          r.midi_first   = BYTE_CONT;
          r.display_code = DISP_PLAY;
        end
        default: begin
          model_mode     = TMODE_PLAYING;
          r.midi_first   = BYTE_START;
          r.display_code = DISP_PLAY;
        end
      endcase
      r.midi_count = 2'd1;
      acted = 1'b1;
    end
    if (button_acts(BTN_STOP, stop)) begin
      model_mode = TMODE_STOPPED;
      // stop byte goes second when play also acted this tick
      if (acted) r.midi_second = BYTE_STOP;
      else r.midi_first = BYTE_STOP;
      r.midi_count   = r.midi_count + 2'd1;
      r.display_code = DISP_STOP;
      acted = 1'b1;
    end
    if (acted) begin
      msg_on      = 1'b1;
      msg_elapsed = '0;
    end else if (msg_on && msg_elapsed != MSG_MAX) begin
      msg_elapsed = msg_elapsed + 1'b1;
    end
    if (msg_on && msg_elapsed >= msg_setting) begin
      msg_on = 1'b0;
      r.display_code = (model_mode == TMODE_STOPPED) ? DISP_IDLE : DISP_BPM;
    end
    r.transport_mode = model_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Tasks enter and leave at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic play, input logic stop);
    if (!calm) begin
      while ($urandom_range(0, 99) < STALL_PCT) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid   = 1'b1;
    play_level = play;
    stop_level = stop;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(transport_tick(play, stop));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic hold_levels(input logic play, input logic stop, input int ticks);
    repeat (ticks) send_tick(play, stop);
  endtask

  // Sender stops until every owed result has come back.
  task automatic wait_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Register write, only with the core drained and settled.
  task automatic write_reg(input logic idx, input logic [CFG_DATA_WIDTH-1:0] value);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == CFG_DEBOUNCE) deb_setting = value[DEB_WIDTH-1:0];
    else msg_setting = value[MSG_WIDTH-1:0];
  endtask

  // Press with debounce 0: two low ticks act, two high ticks clear the latch.
  task automatic quick_press(input logic play_on, input logic stop_on);
    hold_levels(!play_on, !stop_on, 2);
    hold_levels(1'b1, 1'b1, 2);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random backpressure, and the result check.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    dtc_result_t got;
    dtc_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {midi_count, midi_first, midi_second, display_code, transport_mode};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"result %0d arrived with none owed: count %0d first %h second %h",
                    " disp %0d mode %0d"},
                   results_seen, got.midi_count, got.midi_first, got.midi_second,
                   got.display_code, got.transport_mode);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"result %0d (expected/actual): count %0d/%0d first %h/%h second %h/%h",
                      " disp %0d/%0d mode %0d/%0d"},
                     results_seen, want.midi_count, got.midi_count,
                     want.midi_first, got.midi_first, want.midi_second, got.midi_second,
                     want.display_code, got.display_code,
                     want.transport_mode, got.transport_mode);
        end
      end
      results_seen++;
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side is a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (debounce 50): a press acts on its 52nd low tick.
  task automatic test_reset_settings();
    hold_levels(1'b0, 1'b1, 53);
    hold_levels(1'b1, 1'b1, 3);
  endtask

  // Every transport step with no debounce and a short message.
  task automatic test_transport_steps();
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_MESSAGE, 16'd2);
    hold_levels(1'b1, 1'b1, 2);     // the play latch was left set by the previous test
    quick_press(1'b1, 1'b0);        // stopped -> playing, start byte
    quick_press(1'b1, 1'b0);        // playing -> paused, stop byte
    quick_press(1'b1, 1'b0);        // paused -> playing, continue byte
    hold_levels(1'b1, 1'b1, 3);     // idle while playing, after the message ran out to bpm
    quick_press(1'b0, 1'b1);        // stop from playing
    hold_levels(1'b1, 1'b1, 3);     // idle while stopped, after the message ran out to idle
    quick_press(1'b0, 1'b1);        // stop while already stopped
    quick_press(1'b1, 1'b1);        // both at once from stopped: start then stop
    quick_press(1'b1, 1'b0);
    quick_press(1'b1, 1'b1);        // both at once from playing: stop twice
  endtask

  // Message time zero: the view restores in the same tick as the action.
  task automatic test_zero_message();
    write_reg(CFG_MESSAGE, 16'd0);
    quick_press(1'b1, 1'b0);
    quick_press(1'b0, 1'b1);
  endtask

  // Wide debounce write with upper data bits set: only the low ten bits are
  // kept, so 0xFC80 acts as 128 and the press acts on its 130th low tick.
  task automatic test_max_debounce();
    write_reg(CFG_DEBOUNCE, 16'hFC80);
    write_reg(CFG_MESSAGE, 16'd3);
    hold_levels(1'b1, 1'b0, 131);
  endtask

  // Long message while play stays held well past the debounce. Upper data
  // bits are set on the debounce write and must be dropped.
  task automatic test_long_hold();
    calm = 1'b1;
    write_reg(CFG_DEBOUNCE, 16'hFC00);
    write_reg(CFG_MESSAGE, 16'd120);
    hold_levels(1'b1, 1'b1, 3);
    hold_levels(1'b0, 1'b1, 130);
    hold_levels(1'b1, 1'b1, 3);
    calm = 1'b0;
  endtask

  // Mostly clean presses with random length around the debounce setting,
  // mixed with bursts of bouncing levels on both pins.
  task automatic run_random_ticks(input int count);
    int stop_at;
    int pick;
    logic play_on;
    logic stop_on;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        play_on = (pick < 55);
        stop_on = (pick >= 35);
        hold_levels(!play_on, !stop_on, deb_setting + 1 + $urandom_range(0, 4));
        hold_levels(1'b1, 1'b1, deb_setting + 1 + $urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(1, 6))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random();
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_MESSAGE, 16'd1);
    run_random_ticks(70);
    // no idling on either side for this phase
    write_reg(CFG_DEBOUNCE, 16'd2);
    write_reg(CFG_MESSAGE, 16'd6);
    calm = 1'b1;
    run_random_ticks(70);
    calm = 1'b0;
    write_reg(CFG_DEBOUNCE, 16'd5);
    write_reg(CFG_MESSAGE, 16'd25);
    run_random_ticks(40);
    wait_results();
    run_random_ticks(40);
    write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 7)));
    write_reg(CFG_MESSAGE, 16'($urandom_range(0, 40)));
    run_random_ticks(70);
  endtask

  initial begin
    deb_setting = DEB_RESET;
    msg_setting = MSG_RESET;
    model_mode  = TMODE_STOPPED;
    for (int b = 0; b < 2; b++) begin
      btn_prev[b]  = 1'b1;
      btn_count[b] = '0;
      btn_latch[b] = 1'b0;
    end
    msg_on      = 1'b0;
    msg_elapsed = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_settings();
    test_transport_steps();
    test_zero_message();
    test_max_debounce();
    test_long_hold();
    test_random();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
